>>> rtl/dst_pkg.sv
// Shared types, constants and helpers for the date set table.
// Used by dst_ctrl, dst_dp and date_set_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

  localparam int CAPACITY_DEF = 512;

  localparam int OPCODE_W = 2;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int INDEX_W  = 9;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 10;
  localparam int ENTRY_W  = MONTH_W + DAY_W;

  localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_READ,
    S_FINISH
  } dst_state_t;

  typedef struct packed {
    logic capture;   // input transfer, latch the item
    logic init;      // set up scan pointer and flags
    logic scan;      // walk the table
    logic read_idx;  // single read at the item's index
    logic finish;    // form result, commit table update
  } dst_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                range_bad;
    logic                scan_done;
    logic                out_free;
  } dst_sts_t;

  // Days in each month of a non-leap year; month values outside 1..12 give 31.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                    d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dst_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dst_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dst_ctrl.sv
// Controller for the date set table: sequences decode, table walk, read and result.
// Depends on dst_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module dst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dst_pkg::dst_sts_t sts,
  output dst_pkg::dst_cmd_t      cmd
);

  dst_pkg::dst_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      dst_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = dst_pkg::S_DECODE;
        end
      end
      dst_pkg::S_DECODE: begin
        cmd.init = 1'b1;
        case (sts.op)
          dst_pkg::OP_ADD:    state_next = dst_pkg::S_SCAN;
          dst_pkg::OP_REMOVE: state_next = sts.range_bad ? dst_pkg::S_FINISH
                                                         : dst_pkg::S_SCAN;
          dst_pkg::OP_READ:   state_next = sts.range_bad ? dst_pkg::S_FINISH
                                                         : dst_pkg::S_READ;
          default:            state_next = dst_pkg::S_FINISH;
        endcase
      end
      dst_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = dst_pkg::S_FINISH;
        end
      end
      dst_pkg::S_READ: begin
        cmd.read_idx = 1'b1;
        state_next   = dst_pkg::S_FINISH;
      end
      dst_pkg::S_FINISH: begin
        // wait here while the previous result is still unclaimed
        cmd.finish = 1'b1;
        if (sts.out_free) begin
          state_next = dst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dst_dp.sv
// Datapath for the date set table: item registers, table RAM, scan pointer,
// status logic and output register. Depends on dst_pkg and dst_ram.
`timescale 1ns / 1ps
`default_nettype none

module dst_dp #(
  parameter int CAPACITY = dst_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dst_pkg::dst_cmd_t            cmd,
  output dst_pkg::dst_sts_t                 sts,
  input  wire logic [dst_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [dst_pkg::MONTH_W-1:0]  month,
  input  wire logic [dst_pkg::DAY_W-1:0]    day,
  input  wire logic [dst_pkg::INDEX_W-1:0]  index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [dst_pkg::STATUS_W-1:0]      status,
  output logic [dst_pkg::MONTH_W-1:0]       out_month,
  output logic [dst_pkg::DAY_W-1:0]         out_day,
  output logic [dst_pkg::COUNT_W-1:0]       entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = dst_pkg::ENTRY_W;

  // item registers
  logic [dst_pkg::OPCODE_W-1:0] op_r;
  logic [dst_pkg::MONTH_W-1:0]  month_r;
  logic [dst_pkg::DAY_W-1:0]    day_r;
  logic [dst_pkg::INDEX_W-1:0]  idx_r;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr;
  logic [AW-1:0] waddr;
  logic          pend;
  logic          dup;

  logic [EW-1:0] key;
  logic [EW-1:0] rd_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  logic                         range_bad, scan_more, scan_rd, shift_wr;
  logic                         out_free, load, append;
  logic                         month_ok, day_ok, full;
  logic [dst_pkg::STATUS_W-1:0] res_status;
  logic [dst_pkg::MONTH_W-1:0]  res_month;
  logic [dst_pkg::DAY_W-1:0]    res_day;

  assign key       = {month_r, day_r};
  assign range_bad = {1'b0, idx_r} >= dst_pkg::COUNT_W'(count);
  assign scan_more = ptr < count;
  assign scan_rd   = cmd.scan && scan_more;
  // remove: entry read last cycle moves down one place
  assign shift_wr  = pend && (op_r == dst_pkg::OP_REMOVE);
  assign out_free  = !out_valid || out_ready;
  assign load      = cmd.finish && out_free;

  assign sts.op        = op_r;
  assign sts.range_bad = range_bad;
  assign sts.scan_done = !scan_more && !pend;
  assign sts.out_free  = out_free;

  always_comb begin
    month_ok = month_r inside {[dst_pkg::MONTH_MIN:dst_pkg::MONTH_MAX]};
    day_ok   = (day_r != '0) && (day_r <= dst_pkg::month_days(month_r));
    full     = count >= CW'(CAPACITY);
    append     = 1'b0;
    res_status = dst_pkg::ST_OK;
    res_month  = '0;
    res_day    = '0;
    count_next = count;
    case (op_r)
      dst_pkg::OP_ADD: begin
        if (dup) begin
          res_status = dst_pkg::ST_DUP;
        end else if (!month_ok) begin
          res_status = dst_pkg::ST_BAD_MONTH;
        end else if (!day_ok) begin
          res_status = dst_pkg::ST_BAD_DAY;
        end else if (full) begin
          res_status = dst_pkg::ST_FULL;
        end else begin
          append     = load;
          count_next = count + CW'(1);
        end
      end
      dst_pkg::OP_REMOVE: begin
        if (range_bad) begin
          res_status = dst_pkg::ST_RANGE;
        end else begin
          count_next = count - CW'(1);
        end
      end
      dst_pkg::OP_READ: begin
        if (range_bad) begin
          res_status = dst_pkg::ST_RANGE;
        end else begin
          res_month = rd_data[EW-1:dst_pkg::DAY_W];
          res_day   = rd_data[dst_pkg::DAY_W-1:0];
        end
      end
      default: begin
        res_status = dst_pkg::ST_OK;
      end
    endcase
  end

  assign rd_en   = scan_rd || cmd.read_idx;
  assign rd_addr = cmd.read_idx ? idx_r[AW-1:0] : ptr[AW-1:0];
  assign wr_en   = shift_wr || append;
  assign wr_addr = append ? count[AW-1:0] : waddr;
  assign wr_data = append ? key : rd_data;

  dst_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= scan_rd;
      if (load) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= opcode;
      month_r <= month;
      day_r   <= day;
      idx_r   <= index;
    end
    if (cmd.init) begin
      dup <= 1'b0;
      // remove copies from idx+1 downward; add walks from the start
      ptr <= (op_r == dst_pkg::OP_REMOVE) ? CW'(idx_r) + CW'(1) : '0;
    end else if (scan_rd) begin
      ptr   <= ptr + CW'(1);
      waddr <= AW'(ptr - CW'(1));
    end
    if (pend && (op_r == dst_pkg::OP_ADD) && (rd_data == key)) begin
      dup <= 1'b1;
    end
    if (load) begin
      status      <= res_status;
      out_month   <= res_month;
      out_day     <= res_day;
      entry_count <= dst_pkg::COUNT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> count == $past(count))
    else $error("entry count changed outside result load");

  a_shift_in_table: assert property (@(posedge clk) disable iff (rst)
    shift_wr |-> CW'(waddr) < count)
    else $error("compaction write beyond stored entries");

  a_append_free_slot: assert property (@(posedge clk) disable iff (rst)
    append |-> (count < CW'(CAPACITY)) && !dup && !pend)
    else $error("append into full table or after duplicate hit");

endmodule

`default_nettype wire

>>> rtl/date_set_table.sv
// Date set table top level: controller plus datapath with table RAM.
// Depends on dst_pkg, dst_ctrl, dst_dp (which holds dst_ram).
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_ready   | opcode, month, day, index
//  output   | out_valid / out_ready | status, out_month, out_day, entry_count
//
// One item at a time: decode, then add walks the stored entries for a duplicate,
// remove moves each entry above the index down one place, read fetches the entry
// at the index, and an out-of-range remove or read or an unused opcode goes to the
// result. Reset clears the entry count, out_valid and the controller state. A
// finished result sits in the output register; the engine stalls in its final
// step only while that register still holds an untaken result.
`timescale 1ns / 1ps
`default_nettype none

module date_set_table #(
  parameter int CAPACITY = dst_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dst_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [dst_pkg::MONTH_W-1:0]  month,
  input  wire logic [dst_pkg::DAY_W-1:0]    day,
  input  wire logic [dst_pkg::INDEX_W-1:0]  index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [dst_pkg::STATUS_W-1:0]      status,
  output logic [dst_pkg::MONTH_W-1:0]       out_month,
  output logic [dst_pkg::DAY_W-1:0]         out_day,
  output logic [dst_pkg::COUNT_W-1:0]       entry_count
);

  dst_pkg::dst_cmd_t cmd;
  dst_pkg::dst_sts_t sts;

  dst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  dst_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .month      (month),
    .day        (day),
    .index      (index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_month  (out_month),
    .out_day    (out_day),
    .entry_count(entry_count)
  );

endmodule

`default_nettype wire
